// File: rtl/core/wfa_pkg.sv
// wfa_pkg: shared types and constants for the worst-fit allocator.
// No dependencies; used by wfa_table, wfa_best and worst_fit_allocator_unit.
package wfa_pkg;

    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned COUNT_BITS = 5;
    localparam int unsigned SLOT_BITS  = 4;

    // command codes carried on the input word
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // table write request
    typedef struct packed {
        logic load_en;  // write label, original and remaining size
        logic rem_en;   // write remaining size only
    } tbl_wr_t;

endpackage

// File: rtl/core/worst_fit_allocator_unit.sv
// worst_fit_allocator_unit: top level, sequencer and output register.
// Uses wfa_pkg, wfa_table and wfa_best.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command word. A load
//   (command 0) writes label and size into slot entry_index; slots at or
//   above NUM_BLOCKS are ignored. An allocate (command 1) scans the first
//   block_count entries (capped at NUM_BLOCKS) for the largest remaining
//   size that covers request_size, lowest slot on a tie, and shrinks it.
//   Every command returns one word on the output channel (out_valid/
//   out_ready); a load or a miss returns found = 0 and zero fields.
//   Config channel (cfg_valid/cfg_ready) writes block_count; always ready.
//   Sequence: a load or an empty search goes from accept straight to ST_DONE,
//   which writes the result word into the output register. An allocate of N
//   entries steps through ST_SCAN, one table read per cycle through the
//   registered read port, then ST_DRAIN for the last compare, then ST_DONE,
//   which also writes the shrunk size back. in_ready is high only while the
//   sequencer is idle. A finished word waits in the output register; while
//   the receiver stalls the next command is still accepted and processed,
//   and it holds in its final step until the output register frees up.
//   Reset clears the sequencer, the output register and block_count; table
//   contents are undefined until loaded.
module worst_fit_allocator_unit #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // command words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [3:0]  entry_index,
    input  logic [15:0] block_label,
    input  logic [15:0] block_size,
    input  logic [15:0] request_size,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] chosen_label,
    output logic [15:0] chosen_original_size,
    output logic [15:0] leftover
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > wfa_pkg::COUNT_BITS) ? CNT_W : wfa_pkg::COUNT_BITS;
    localparam int FB    = wfa_pkg::FIELD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg,     state_next;
    logic [4:0]           count_reg;
    logic [CNT_W-1:0]     issue_reg,     issue_next;
    logic [CNT_W-1:0]     limit_reg,     limit_next;
    logic [SIZE_BITS-1:0] req_reg,       req_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg,   cmp_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg,     found_next;
    logic [FB-1:0]        label_reg,     label_next;
    logic [FB-1:0]        orig_reg,      orig_next;
    logic [FB-1:0]        left_reg,      left_next;

    logic                 in_fire;
    logic                 slot_ok;
    logic [LIM_W-1:0]     count_ext;
    logic [LIM_W-1:0]     limit_calc;
    logic                 out_free;
    logic                 finish;

    wfa_pkg::tbl_wr_t     tbl_wr;
    logic [IDX_W-1:0]     tbl_wr_addr;
    logic [SIZE_BITS-1:0] tbl_wr_size;
    logic [FB-1:0]        rd_label;
    logic [SIZE_BITS-1:0] rd_orig;
    logic [SIZE_BITS-1:0] rd_rem;

    logic                 have;
    logic [IDX_W-1:0]     best_idx;
    logic [FB-1:0]        best_label;
    logic [SIZE_BITS-1:0] best_orig;
    logic [SIZE_BITS-1:0] best_rem;
    logic [SIZE_BITS-1:0] left_size;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign slot_ok    = ({28'd0, entry_index} < 32'(NUM_BLOCKS));
    assign count_ext  = LIM_W'(count_reg);
    assign limit_calc = (count_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : count_ext;
    assign out_free   = !out_valid_reg || out_ready;
    assign finish     = (state_reg == ST_DONE) && out_free;
    assign left_size  = best_rem - req_reg;

    // load writes at accept; allocate writes the shrunk size back at finish if it found a block
    always_comb
    begin
        tbl_wr.load_en = in_fire && (command == wfa_pkg::CMD_LOAD) && slot_ok;
        tbl_wr.rem_en  = finish && have;
        if (tbl_wr.load_en)
        begin
            tbl_wr_addr = IDX_W'(entry_index);
            tbl_wr_size = SIZE_BITS'(block_size);
        end
        else
        begin
            tbl_wr_addr = best_idx;
            tbl_wr_size = left_size;
        end
    end

    wfa_table #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr       (tbl_wr),
        .wr_addr  (tbl_wr_addr),
        .wr_label (block_label),
        .wr_size  (tbl_wr_size),
        .rd_addr  (issue_reg[IDX_W-1:0]),
        .rd_label (rd_label),
        .rd_orig  (rd_orig),
        .rd_rem   (rd_rem)
    );

    wfa_best #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (in_fire),
        .cmp_valid  (cmp_valid_reg),
        .cmp_idx    (cmp_idx_reg),
        .cmp_label  (rd_label),
        .cmp_orig   (rd_orig),
        .cmp_rem    (rd_rem),
        .req        (req_reg),
        .have       (have),
        .best_idx   (best_idx),
        .best_label (best_label),
        .best_orig  (best_orig),
        .best_rem   (best_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        limit_next     = limit_reg;
        req_next       = req_reg;
        cmp_valid_next = (state_reg == ST_SCAN);
        cmp_idx_next   = issue_reg[IDX_W-1:0];
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        label_next     = label_reg;
        orig_next      = orig_reg;
        left_next      = left_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    issue_next = '0;
                    limit_next = CNT_W'(limit_calc);
                    req_next   = SIZE_BITS'(request_size);
                    if ((command == wfa_pkg::CMD_ALLOC) && (limit_calc != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                issue_next = issue_reg + 1'b1;
                if ((issue_reg + 1'b1) == limit_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last entry is compared this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = have;
                    label_next     = have ? best_label : '0;
                    orig_next      = have ? FB'(best_orig) : '0;
                    left_next      = have ? FB'(left_size) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            limit_reg     <= '0;
            req_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            label_reg     <= '0;
            orig_reg      <= '0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            limit_reg     <= limit_next;
            req_reg       <= req_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            label_reg     <= label_next;
            orig_reg      <= orig_next;
            left_reg      <= left_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign found                = found_reg;
    assign chosen_label         = label_reg;
    assign chosen_original_size = orig_reg;
    assign leftover             = left_reg;

endmodule

// File: rtl/core/wfa_table.sv
// wfa_table: block table memories (label, original size, remaining size).
// One write port, one shared registered read port. Depends on wfa_pkg.
module wfa_table #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 4
) (
    input  logic                           clk,
    input  wfa_pkg::tbl_wr_t               wr,
    input  logic [IDX_W-1:0]               wr_addr,
    input  logic [wfa_pkg::FIELD_BITS-1:0] wr_label,
    input  logic [SIZE_BITS-1:0]           wr_size,
    input  logic [IDX_W-1:0]               rd_addr,
    output logic [wfa_pkg::FIELD_BITS-1:0] rd_label,
    output logic [SIZE_BITS-1:0]           rd_orig,
    output logic [SIZE_BITS-1:0]           rd_rem
);

    logic [wfa_pkg::FIELD_BITS-1:0] label_mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]           orig_mem  [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]           rem_mem   [NUM_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.load_en)
        begin
            label_mem[wr_addr] <= wr_label;
            orig_mem[wr_addr]  <= wr_size;
        end
        if (wr.load_en || wr.rem_en)
        begin
            rem_mem[wr_addr] <= wr_size;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_label <= label_mem[rd_addr];
        rd_orig  <= orig_mem[rd_addr];
        rd_rem   <= rem_mem[rd_addr];
    end

endmodule

// File: rtl/core/wfa_best.sv
// wfa_best: running worst-fit selection over entries streamed from the table.
// Keeps the best candidate so far. Depends on wfa_pkg.
module wfa_best #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           cmp_valid,
    input  logic [IDX_W-1:0]               cmp_idx,
    input  logic [wfa_pkg::FIELD_BITS-1:0] cmp_label,
    input  logic [SIZE_BITS-1:0]           cmp_orig,
    input  logic [SIZE_BITS-1:0]           cmp_rem,
    input  logic [SIZE_BITS-1:0]           req,
    output logic                           have,
    output logic [IDX_W-1:0]               best_idx,
    output logic [wfa_pkg::FIELD_BITS-1:0] best_label,
    output logic [SIZE_BITS-1:0]           best_orig,
    output logic [SIZE_BITS-1:0]           best_rem
);

    logic                           have_reg,  have_next;
    logic [IDX_W-1:0]               idx_reg,   idx_next;
    logic [wfa_pkg::FIELD_BITS-1:0] label_reg, label_next;
    logic [SIZE_BITS-1:0]           orig_reg,  orig_next;
    logic [SIZE_BITS-1:0]           rem_reg,   rem_next;
    logic                           take;

    // strictly larger keeps the lowest index on a tie
    assign take = cmp_valid && (cmp_rem >= req) && (!have_reg || (cmp_rem > rem_reg));

    always_comb
    begin
        have_next  = have_reg;
        idx_next   = idx_reg;
        label_next = label_reg;
        orig_next  = orig_reg;
        rem_next   = rem_reg;
        if (clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next  = 1'b1;
            idx_next   = cmp_idx;
            label_next = cmp_label;
            orig_next  = cmp_orig;
            rem_next   = cmp_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        label_reg <= label_next;
        orig_reg  <= orig_next;
        rem_reg   <= rem_next;
    end

    assign have       = have_reg;
    assign best_idx   = idx_reg;
    assign best_label = label_reg;
    assign best_orig  = orig_reg;
    assign best_rem   = rem_reg;

endmodule
